>>> rtl/two_way_traffic_light_sequencer_core_macros.svh
// ----------------------------------------------------------------------------
// Traffic light sequencer assertion macros
// Clocked property shorthands shared by the sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef TWO_WAY_TRAFFIC_LIGHT_SEQUENCER_CORE_MACROS_SVH
`define TWO_WAY_TRAFFIC_LIGHT_SEQUENCER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TLSQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tlsq assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TLSQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tlsq assertion failed");

`endif

>>> rtl/tlsq_pkg.sv
// ----------------------------------------------------------------------------
// Traffic light sequencer package
// Shared types, lamp masks, register indexes and digit helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package tlsq_pkg;

	localparam int CountW = 7;
	localparam int TicksW = 4;
	localparam int DigitW = 4;
	localparam int LampW  = 6;
	localparam int IndexW = 3;

	localparam logic [CountW-1:0] CountTop  = 7'd99;
	localparam logic [TicksW-1:0] TicksTop  = 4'd9;

	localparam logic [LampW-1:0] LAMP_RED1    = 6'b000001;
	localparam logic [LampW-1:0] LAMP_YELLOW1 = 6'b000010;
	localparam logic [LampW-1:0] LAMP_GREEN1  = 6'b000100;
	localparam logic [LampW-1:0] LAMP_RED2    = 6'b001000;
	localparam logic [LampW-1:0] LAMP_YELLOW2 = 6'b010000;
	localparam logic [LampW-1:0] LAMP_GREEN2  = 6'b100000;

	typedef enum logic [IndexW-1:0] {
		REG_PHASE_ONE_START     = 3'd0,
		REG_YELLOW_ONE_AT       = 3'd1,
		REG_PHASE_TWO_START     = 3'd2,
		REG_GREEN_TWO_AT        = 3'd3,
		REG_MANUAL_YELLOW_TICKS = 3'd4
	} reg_index_t;

	typedef enum logic [3:0] {
		MODE_AUTO_RESTART = 4'b0001,
		MODE_AUTO_RUN     = 4'b0010,
		MODE_MAN_YELLOW   = 4'b0100,
		MODE_MAN_HOLD     = 4'b1000
	} mode_t;

	typedef struct packed {
		logic [CountW-1:0] phase_one_start;
		logic [CountW-1:0] yellow_one_at;
		logic [CountW-1:0] phase_two_start;
		logic [CountW-1:0] green_two_at;
		logic [TicksW-1:0] manual_yellow_ticks;
	} cfg_t;

	typedef struct packed {
		logic [DigitW-1:0] tens;
		logic [DigitW-1:0] units;
	} digits_t;

	typedef struct packed {
		logic [LampW-1:0] lamps;
		digits_t          digits;
	} result_t;

	function automatic logic [CountW-1:0] clamp_count(input logic [CountW-1:0] v);
		return (v > CountTop) ? CountTop : v;
	endfunction

	function automatic logic [TicksW-1:0] clamp_ticks(input logic [TicksW-1:0] v);
		return (v > TicksTop) ? TicksTop : v;
	endfunction

	// Tens by reciprocal multiply (205/2048), exact for values up to 99.
	function automatic digits_t to_digits(input logic [CountW-1:0] v);
		logic [14:0]       prod;
		logic [CountW-1:0] tens_x10;
		digits_t           d;
		prod     = 15'(v) * 15'd205;
		d.tens   = prod[14:11];
		tens_x10 = 7'(d.tens) * 7'd10;
		d.units  = 4'(v - tens_x10);
		return d;
	endfunction

endpackage

`default_nettype wire

>>> rtl/tlsq_cfg_regs.sv
// ----------------------------------------------------------------------------
// Traffic light sequencer configuration registers
// Holds the phase counts and manual yellow length written over the write port.
// ----------------------------------------------------------------------------
`default_nettype none

module tlsq_cfg_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          wr_en,
	input  wire logic [tlsq_pkg::IndexW-1:0]   wr_index,
	input  wire logic [tlsq_pkg::CountW-1:0]   wr_data,
	output tlsq_pkg::cfg_t                     cfg
);
	import tlsq_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_one_start     <= 7'd23;
			cfg_q.yellow_one_at       <= 7'd3;
			cfg_q.phase_two_start     <= 7'd15;
			cfg_q.green_two_at        <= 7'd12;
			cfg_q.manual_yellow_ticks <= 4'd3;
		end else if (wr_en) begin
			unique case (reg_index_t'(wr_index))
				REG_PHASE_ONE_START:     cfg_q.phase_one_start     <= wr_data;
				REG_YELLOW_ONE_AT:       cfg_q.yellow_one_at       <= wr_data;
				REG_PHASE_TWO_START:     cfg_q.phase_two_start     <= wr_data;
				REG_GREEN_TWO_AT:        cfg_q.green_two_at        <= wr_data;
				REG_MANUAL_YELLOW_TICKS: cfg_q.manual_yellow_ticks <= wr_data[TicksW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> rtl/tlsq_seq.sv
// ----------------------------------------------------------------------------
// Traffic light sequencer state and tick logic
// Holds the sequence state and works out one tick's lamps and countdown.
// ----------------------------------------------------------------------------
`default_nettype none

module tlsq_seq (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire logic          manual_mode,
	input  wire logic          direction,
	input  wire tlsq_pkg::cfg_t cfg,
	output tlsq_pkg::result_t  result
);
	import tlsq_pkg::*;

	mode_t             mode_q, mode_d;
	logic              phase_q, phase_d;
	logic [CountW-1:0] count_q, count_d;
	logic [TicksW-1:0] mcount_q, mcount_d;
	logic              road_q, road_d;
	logic [LampW-1:0]  lamps_q, lamps_d;
	logic [CountW-1:0] shown;

	always_comb begin
		mode_d   = mode_q;
		phase_d  = phase_q;
		count_d  = count_q;
		mcount_d = mcount_q;
		road_d   = road_q;
		lamps_d  = lamps_q;
		shown    = '0;
		if (manual_mode) begin
			if (mode_q == MODE_AUTO_RESTART || mode_q == MODE_AUTO_RUN ||
				(mode_q == MODE_MAN_HOLD && direction != road_q)) begin
				road_d   = direction;
				mcount_d = clamp_ticks(cfg.manual_yellow_ticks);
				lamps_d  = LAMP_YELLOW1 | LAMP_YELLOW2;
				mode_d   = MODE_MAN_YELLOW;
			end
			if (mode_d == MODE_MAN_YELLOW) begin
				if (mcount_d != '0) begin
					shown    = 7'(mcount_d);
					mcount_d = mcount_d - 4'd1;
				end else begin
					lamps_d = road_d ? (LAMP_GREEN2 | LAMP_RED1) : (LAMP_GREEN1 | LAMP_RED2);
					mode_d  = MODE_MAN_HOLD;
				end
			end
		end else begin
			// Any automatic tick that does not follow a running automatic tick
			// restarts phase one from the top.
			if (mode_q != MODE_AUTO_RUN) begin
				lamps_d = '0;
				phase_d = 1'b0;
				count_d = clamp_count(cfg.phase_one_start);
				mode_d  = MODE_AUTO_RUN;
			end
			shown = clamp_count(count_d);
			if (!phase_d) begin
				if (shown == clamp_count(cfg.phase_one_start)) begin
					lamps_d = LAMP_GREEN1 | LAMP_RED2;
				end
				if (shown == cfg.yellow_one_at) begin
					lamps_d = (lamps_d & ~LAMP_GREEN1) | LAMP_YELLOW1;
				end
			end else begin
				if (shown == clamp_count(cfg.phase_two_start)) begin
					lamps_d = (lamps_d & ~(LAMP_YELLOW1 | LAMP_RED2)) | LAMP_YELLOW2 | LAMP_RED1;
				end
				if (shown == cfg.green_two_at) begin
					lamps_d = (lamps_d & ~LAMP_YELLOW2) | LAMP_GREEN2;
				end
			end
			if (shown == '0) begin
				phase_d = ~phase_d;
				count_d = clamp_count(phase_d ? cfg.phase_two_start : cfg.phase_one_start);
			end else begin
				count_d = shown - 7'd1;
			end
		end
		result.lamps  = lamps_d;
		result.digits = to_digits(shown);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_AUTO_RESTART;
			phase_q  <= 1'b0;
			count_q  <= 7'd23;
			mcount_q <= '0;
			road_q   <= 1'b0;
			lamps_q  <= '0;
		end else if (step) begin
			mode_q   <= mode_d;
			phase_q  <= phase_d;
			count_q  <= count_d;
			mcount_q <= mcount_d;
			road_q   <= road_d;
			lamps_q  <= lamps_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/two_way_traffic_light_sequencer_core.sv
// ----------------------------------------------------------------------------
// Two-way traffic light sequencer core
// Turns one-second ticks into six lamp levels and a two-digit countdown.
// ----------------------------------------------------------------------------
// Channel   Handshake              Payload
// tick      tick_valid/tick_stall  manual_mode, direction
// lamp      lamp_valid/lamp_stall  six lamps, tens_digit, units_digit
// config    wr_en                  wr_index, wr_data
//
// A tick enters the input register, then its lamps and countdown sit in
// the result register: one tick per cycle sustained while lamp_stall is low.
// The single state update between the two registers sets this rate.
// Reset restarts automatic mode at the top of phase one.
// A stall on the lamp channel holds the result and then the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module two_way_traffic_light_sequencer_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        wr_en,
	input  wire logic [tlsq_pkg::IndexW-1:0] wr_index,
	input  wire logic [tlsq_pkg::CountW-1:0] wr_data,
	input  wire logic                        tick_valid,
	output logic                             tick_stall,
	input  wire logic                        manual_mode,
	input  wire logic                        direction,
	output logic                             lamp_valid,
	input  wire logic                        lamp_stall,
	output logic                             red_one,
	output logic                             yellow_one,
	output logic                             green_one,
	output logic                             red_two,
	output logic                             yellow_two,
	output logic                             green_two,
	output logic [tlsq_pkg::DigitW-1:0]      tens_digit,
	output logic [tlsq_pkg::DigitW-1:0]      units_digit
);
	import tlsq_pkg::*;

`include "two_way_traffic_light_sequencer_core_macros.svh"

	cfg_t    cfg;
	result_t result;
	result_t result_q;
	logic    valid_s1;
	logic    manual_s1;
	logic    direction_s1;
	logic    out_valid_q;
	logic    advance;
	logic    accept;

	// The input register moves on whenever the result register is free or
	// is being emptied in the same cycle.
	assign advance    = valid_s1 && (!out_valid_q || !lamp_stall);
	assign tick_stall = valid_s1 && !advance;
	assign accept     = tick_valid && !tick_stall;

	tlsq_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	tlsq_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.manual_mode (manual_s1),
		.direction   (direction_s1),
		.cfg         (cfg),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			manual_s1    <= manual_mode;
			direction_s1 <= direction;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!lamp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign lamp_valid  = out_valid_q;
	assign red_one     = result_q.lamps[0];
	assign yellow_one  = result_q.lamps[1];
	assign green_one   = result_q.lamps[2];
	assign red_two     = result_q.lamps[3];
	assign yellow_two  = result_q.lamps[4];
	assign green_two   = result_q.lamps[5];
	assign tens_digit  = result_q.digits.tens;
	assign units_digit = result_q.digits.units;

	// A blocked result must hold the pending tick in the input register.
	`TLSQ_ASSERT_NEXT(a_s1_held, clk, arst_n, valid_s1 && out_valid_q && lamp_stall, valid_s1)
	`TLSQ_ASSERT_NOW(a_no_take_when_full, clk, arst_n, valid_s1 && out_valid_q && lamp_stall, tick_stall)
	`TLSQ_ASSERT_NOW(a_decimal_digits, clk, arst_n, lamp_valid, tens_digit <= 4'd9 && units_digit <= 4'd9)

endmodule

`default_nettype wire
